// ----- rtl/assert_macros.svh -----
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define RV_ASSERT(name, prop) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");

// Condition must never be true outside reset.
`define RV_NEVER(name, cond) \
    `RV_ASSERT(name, !(cond))

`else

`define RV_ASSERT(name, prop)
`define RV_NEVER(name, cond)

`endif

`endif

// ----- rtl/rv64ie_pkg.sv -----
// ============================================================================
// rv64ie_pkg
// Types, operation codes and helpers of the RV64I integer execute unit.
// ============================================================================
package rv64ie_pkg;

    localparam int XLEN          = 64;
    localparam int REG_COUNT_DEF = 32;
    localparam int IDX_W         = 5;
    localparam int IMM_W         = 32;
    localparam int OP_W          = 5;

    localparam logic [OP_W-1:0] OP_AND   = 5'd0;
    localparam logic [OP_W-1:0] OP_OR    = 5'd1;
    localparam logic [OP_W-1:0] OP_XOR   = 5'd2;
    localparam logic [OP_W-1:0] OP_SLL   = 5'd3;
    localparam logic [OP_W-1:0] OP_SRL   = 5'd4;
    localparam logic [OP_W-1:0] OP_SRA   = 5'd5;
    localparam logic [OP_W-1:0] OP_SLT   = 5'd6;
    localparam logic [OP_W-1:0] OP_SLTU  = 5'd7;
    localparam logic [OP_W-1:0] OP_ANDI  = 5'd8;
    localparam logic [OP_W-1:0] OP_ORI   = 5'd9;
    localparam logic [OP_W-1:0] OP_XORI  = 5'd10;
    localparam logic [OP_W-1:0] OP_SLLI  = 5'd11;
    localparam logic [OP_W-1:0] OP_SRLI  = 5'd12;
    localparam logic [OP_W-1:0] OP_SRAI  = 5'd13;
    localparam logic [OP_W-1:0] OP_SLTI  = 5'd14;
    localparam logic [OP_W-1:0] OP_SLTIU = 5'd15;
    localparam logic [OP_W-1:0] OP_ADDW  = 5'd16;
    localparam logic [OP_W-1:0] OP_SUBW  = 5'd17;
    localparam logic [OP_W-1:0] OP_ADDIW = 5'd18;
    localparam logic [OP_W-1:0] OP_SLLW  = 5'd19;
    localparam logic [OP_W-1:0] OP_SRLW  = 5'd20;
    localparam logic [OP_W-1:0] OP_SRAW  = 5'd21;
    localparam logic [OP_W-1:0] OP_AUIPC = 5'd22;
    localparam logic [OP_W-1:0] OP_SLLIW = 5'd23;
    localparam logic [OP_W-1:0] OP_SRLIW = 5'd24;
    localparam logic [OP_W-1:0] OP_SRAIW = 5'd25;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [XLEN-1:0] src1;
        logic [XLEN-1:0] src2;
        logic [XLEN-1:0] imm;
        logic [XLEN-1:0] pc;
    } t_alu_req;

    typedef struct packed {
        logic            valid;
        logic [XLEN-1:0] value;
    } t_alu_res;

    function automatic logic [XLEN-1:0] sext32(input logic [31:0] v);
        return {{(XLEN-32){v[31]}}, v};
    endfunction

endpackage

// ----- rtl/rv64i_integer_execute_unit.sv -----
// ============================================================================
// rv64i_integer_execute_unit
// RV64I integer execute unit with a 32 x 64-bit register file.
// ============================================================================
// The unit takes one decoded instruction per cycle while the output is not
// stalled and returns one word per instruction through the stage-1 register
// and the output register. In the acceptance cycle both source registers are
// read from two copies of the register file RAM; when stage 1 advances, the
// ALU result is written to the RAMs and loaded into the output register. A
// last-write register forwards the newest result, so back-to-back dependent
// instructions see each other without stalls. Register contents read as zero
// after reset through per-register written flags, so no clearing pass runs.
// A result with write_done low reports index zero and value zero; this covers
// destination x0 and unknown operation selectors.
`include "assert_macros.svh"

module rv64i_integer_execute_unit
    import rv64ie_pkg::*;
#(
    parameter int REG_COUNT = REG_COUNT_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // dest_index[4:0], src1_index[9:5], src2_index[14:10], immediate[46:15],
    // instr_address[110:47], zero padding[111].
    input  logic [111:0] s_axis_tdata,
    // req_type[4:0].
    input  logic [4:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // written_index[4:0], written_value[68:5], zero padding[71:69].
    output logic [71:0]  m_axis_tdata,
    // write_done.
    output logic         m_axis_tuser
);

    localparam int ADDR_W = $clog2(REG_COUNT);

    logic [IDX_W-1:0]  in_rd;
    logic [IDX_W-1:0]  in_rs1;
    logic [IDX_W-1:0]  in_rs2;
    logic [IMM_W-1:0]  in_imm;
    logic [XLEN-1:0]   in_pc;
    logic              in_accept;
    logic              s1_advance;

    logic              r_s1_valid;
    logic [OP_W-1:0]   r_s1_op;
    logic [IDX_W-1:0]  r_s1_rd;
    logic [IDX_W-1:0]  r_s1_rs1;
    logic [IDX_W-1:0]  r_s1_rs2;
    logic [IMM_W-1:0]  r_s1_imm;
    logic [XLEN-1:0]   r_s1_pc;

    logic [REG_COUNT-1:0] r_written;
    logic [REG_COUNT-1:0] n_written;
    logic              r_wb_valid;
    logic [ADDR_W-1:0] r_wb_idx;
    logic [XLEN-1:0]   r_wb_val;

    logic              r_out_valid;
    logic [IDX_W-1:0]  r_out_idx;
    logic [XLEN-1:0]   r_out_val;
    logic              r_out_done;

    logic [XLEN-1:0]   ram1_rdata;
    logic [XLEN-1:0]   ram2_rdata;
    logic [ADDR_W-1:0] s1_rs1_a;
    logic [ADDR_W-1:0] s1_rs2_a;
    logic [ADDR_W-1:0] s1_rd_a;
    logic [XLEN-1:0]   opnd1;
    logic [XLEN-1:0]   opnd2;
    t_alu_req          alu_req;
    t_alu_res          alu_res;
    logic              do_write;

    assign in_rd  = s_axis_tdata[4:0];
    assign in_rs1 = s_axis_tdata[9:5];
    assign in_rs2 = s_axis_tdata[14:10];
    assign in_imm = s_axis_tdata[46:15];
    assign in_pc  = s_axis_tdata[110:47];

    assign s1_advance    = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign s1_rs1_a = r_s1_rs1[ADDR_W-1:0];
    assign s1_rs2_a = r_s1_rs2[ADDR_W-1:0];
    assign s1_rd_a  = r_s1_rd[ADDR_W-1:0];

    rv64ie_ram #(
        .WIDTH (XLEN),
        .DEPTH (REG_COUNT)
    ) u_ram_src1 (
        .i_clk   (i_clk),
        .i_we    (do_write),
        .i_waddr (s1_rd_a),
        .i_wdata (alu_res.value),
        .i_re    (in_accept),
        .i_raddr (in_rs1[ADDR_W-1:0]),
        .o_rdata (ram1_rdata)
    );

    rv64ie_ram #(
        .WIDTH (XLEN),
        .DEPTH (REG_COUNT)
    ) u_ram_src2 (
        .i_clk   (i_clk),
        .i_we    (do_write),
        .i_waddr (s1_rd_a),
        .i_wdata (alu_res.value),
        .i_re    (in_accept),
        .i_raddr (in_rs2[ADDR_W-1:0]),
        .o_rdata (ram2_rdata)
    );

    always_comb begin
        if (s1_rs1_a == '0) begin
            opnd1 = '0;
        end else if (r_wb_valid && (r_wb_idx == s1_rs1_a)) begin
            opnd1 = r_wb_val;
        end else if (r_written[s1_rs1_a]) begin
            opnd1 = ram1_rdata;
        end else begin
            opnd1 = '0;
        end
        if (s1_rs2_a == '0) begin
            opnd2 = '0;
        end else if (r_wb_valid && (r_wb_idx == s1_rs2_a)) begin
            opnd2 = r_wb_val;
        end else if (r_written[s1_rs2_a]) begin
            opnd2 = ram2_rdata;
        end else begin
            opnd2 = '0;
        end
    end

    assign alu_req.op   = r_s1_op;
    assign alu_req.src1 = opnd1;
    assign alu_req.src2 = opnd2;
    assign alu_req.imm  = sext32(r_s1_imm);
    assign alu_req.pc   = r_s1_pc;

    rv64ie_alu u_alu (
        .i_req (alu_req),
        .o_res (alu_res)
    );

    assign do_write = s1_advance && alu_res.valid && (s1_rd_a != '0);

    always_comb begin
        n_written = r_written;
        if (do_write) begin
            n_written[s1_rd_a] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_written   <= '0;
            r_wb_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_advance) begin
                r_s1_valid <= 1'b0;
            end
            r_written <= n_written;
            if (do_write) begin
                r_wb_valid <= 1'b1;
            end
            if (s1_advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_op  <= s_axis_tuser;
            r_s1_rd  <= in_rd;
            r_s1_rs1 <= in_rs1;
            r_s1_rs2 <= in_rs2;
            r_s1_imm <= in_imm;
            r_s1_pc  <= in_pc;
        end
        if (do_write) begin
            r_wb_idx <= s1_rd_a;
            r_wb_val <= alu_res.value;
        end
        if (s1_advance) begin
            if (do_write) begin
                r_out_idx  <= r_s1_rd;
                r_out_val  <= alu_res.value;
                r_out_done <= 1'b1;
            end else begin
                r_out_idx  <= '0;
                r_out_val  <= '0;
                r_out_done <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_val, r_out_idx};
    assign m_axis_tuser  = r_out_done;

    `RV_NEVER(a_x0_never_written, r_written[0] || (r_wb_valid && (r_wb_idx == '0)))
    `RV_NEVER(a_no_write_is_zero, r_out_valid && !r_out_done && ({r_out_idx, r_out_val} != '0))
    `RV_NEVER(a_done_has_index, r_out_valid && r_out_done && (r_out_idx == '0))
    `RV_ASSERT(a_advance_loads_out, s1_advance |=> r_out_valid)
    `RV_ASSERT(a_write_forwarded, do_write |=> (r_wb_valid && (r_wb_val == $past(alu_res.value))))

endmodule

// ----- rtl/rv64ie_ram.sv -----
// ============================================================================
// rv64ie_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ============================================================================
module rv64ie_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/rv64ie_alu.sv -----
// ============================================================================
// rv64ie_alu
// Combinational RV64I logic, shift, compare, W-form and AUIPC datapath.
// ============================================================================
module rv64ie_alu
    import rv64ie_pkg::*;
(
    input  t_alu_req i_req,
    output t_alu_res o_res
);

    logic [XLEN-1:0] a;
    logic [XLEN-1:0] b;
    logic [XLEN-1:0] imm;
    logic [5:0]      sh64r;
    logic [5:0]      sh64i;
    logic [4:0]      sh32r;
    logic [4:0]      sh32i;
    logic [31:0]     lo;
    logic [31:0]     addw;
    logic [31:0]     subw;
    logic [31:0]     addiw;
    logic [31:0]     sllw;
    logic [31:0]     srlw;
    logic [31:0]     sraw;
    logic [31:0]     slliw;
    logic [31:0]     srliw;
    logic [31:0]     sraiw;

    assign a     = i_req.src1;
    assign b     = i_req.src2;
    assign imm   = i_req.imm;
    assign sh64r = b[5:0];
    assign sh64i = imm[5:0];
    assign sh32r = b[4:0];
    assign sh32i = imm[4:0];
    assign lo    = a[31:0];
    assign addw  = lo + b[31:0];
    assign subw  = lo - b[31:0];
    assign addiw = lo + imm[31:0];
    assign sllw  = lo << sh32r;
    assign srlw  = lo >> sh32r;
    assign sraw  = $signed(lo) >>> sh32r;
    assign slliw = lo << sh32i;
    assign srliw = lo >> sh32i;
    assign sraiw = $signed(lo) >>> sh32i;

    always_comb begin
        o_res.valid = 1'b1;
        o_res.value = '0;
        unique case (i_req.op)
            OP_AND:   o_res.value = a & b;
            OP_OR:    o_res.value = a | b;
            OP_XOR:   o_res.value = a ^ b;
            OP_SLL:   o_res.value = a << sh64r;
            OP_SRL:   o_res.value = a >> sh64r;
            OP_SRA:   o_res.value = $signed(a) >>> sh64r;
            OP_SLT:   o_res.value = {{(XLEN-1){1'b0}}, $signed(a) < $signed(b)};
            OP_SLTU:  o_res.value = {{(XLEN-1){1'b0}}, a < b};
            OP_ANDI:  o_res.value = a & imm;
            OP_ORI:   o_res.value = a | imm;
            OP_XORI:  o_res.value = a ^ imm;
            OP_SLLI:  o_res.value = a << sh64i;
            OP_SRLI:  o_res.value = a >> sh64i;
            OP_SRAI:  o_res.value = $signed(a) >>> sh64i;
            OP_SLTI:  o_res.value = {{(XLEN-1){1'b0}}, $signed(a) < $signed(imm)};
            OP_SLTIU: o_res.value = {{(XLEN-1){1'b0}}, a < imm};
            OP_ADDW:  o_res.value = sext32(addw);
            OP_SUBW:  o_res.value = sext32(subw);
            OP_ADDIW: o_res.value = sext32(addiw);
            OP_SLLW:  o_res.value = sext32(sllw);
            OP_SRLW:  o_res.value = sext32(srlw);
            OP_SRAW:  o_res.value = sext32(sraw);
            OP_AUIPC: o_res.value = i_req.pc + imm;
            OP_SLLIW: o_res.value = sext32(slliw);
            OP_SRLIW: o_res.value = sext32(srliw);
            OP_SRAIW: o_res.value = sext32(sraiw);
            default:  o_res.valid = 1'b0;
        endcase
    end

endmodule
